@@ rtl/prf_pkg.sv @@
// Shared types and constants for the paged register file with unlock key.
// Used by prf_pages, paged_register_file_with_unlock and prf_checker.
package prf_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_READ       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_SOFT_RESET = 2'd2,
    OP_NOP        = 2'd3
  } prf_op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PAGE_SELECT_ADDR = 3'd0,
    CFG_PRODUCT_ID_ADDR  = 3'd1,
    CFG_UNLOCK_KEY_ADDR  = 3'd2,
    CFG_NVM_CONTROL_ADDR = 3'd3,
    CFG_NVM_SAVE_CODE    = 3'd4,
    CFG_NVM_RESTORE_CODE = 3'd5,
    CFG_PRODUCT_ID_VALUE = 3'd6
  } prf_cfg_idx_t;

  localparam int CFG_COUNT = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] CFG_RESET [CFG_COUNT] = '{
    8'd32, 8'd33, 8'd34, 8'd35, 8'd1, 8'd2, 8'd69
  };

  // Key byte i must equal KEY_BASE + i
  localparam logic [7:0] KEY_BASE = 8'h24;

  // Page register width (covers up to 16 pages)
  localparam int PAGE_W = 4;

  // Request and response beats
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
  } prf_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
    logic       unlocked;
  } prf_rsp_t;

  // Top-level sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } prf_state_t;

  // Store sweeper states
  typedef enum logic [1:0] {
    SW_CLEAR,
    SW_IDLE,
    SW_COPY
  } prf_sweep_state_t;

  // Copy direction
  typedef enum logic {
    DIR_SAVE,     // working -> shadow
    DIR_RESTORE   // shadow -> working
  } prf_dir_t;

  // Sweep command from the sequencer to the store
  typedef struct packed {
    logic     go;
    prf_dir_t dir;
  } prf_sweep_cmd_t;

endpackage

@@ rtl/prf_pages.sv @@
// Working and shadow page stores with clear and copy sweeper.
// Depends on prf_pkg for sweep state and command types.
module prf_pages #(
  parameter int  DEPTH  = 266,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [7:0]                   rd_data,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [7:0]                   wr_data,
  input  prf_pkg::prf_sweep_cmd_t      sweep,
  output logic                         busy
);

  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [7:0] working [DEPTH];
  logic [7:0] shadow  [DEPTH];

  prf_pkg::prf_sweep_state_t sw_state, sw_state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  prf_pkg::prf_dir_t dir;
  logic              cp_wr_valid;
  logic [ADDR_W-1:0] cp_wr_addr;
  logic [7:0]        wk_q, sh_q;

  logic              copy_rd;
  logic [ADDR_W-1:0] raddr;
  logic              wk_we, sh_we;
  logic [ADDR_W-1:0] wk_waddr, sh_waddr;
  logic [7:0]        wk_wdata, sh_wdata;

  // Sweeper next state
  always_comb begin
    sw_state_next = sw_state;
    cnt_next      = cnt;
    unique case (sw_state)
      prf_pkg::SW_CLEAR: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DEPTH - 1)) begin
          sw_state_next = prf_pkg::SW_IDLE;
          cnt_next      = '0;
        end
      end
      prf_pkg::SW_IDLE: begin
        if (sweep.go) begin
          sw_state_next = prf_pkg::SW_COPY;
          cnt_next      = '0;
        end
      end
      prf_pkg::SW_COPY: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DEPTH)) begin
          sw_state_next = prf_pkg::SW_IDLE;
          cnt_next      = '0;
        end
      end
      default: begin
        sw_state_next = prf_pkg::SW_IDLE;
      end
    endcase
  end

  // Sweeper outputs: read port mux and write port mux
  always_comb begin
    busy     = (sw_state != prf_pkg::SW_IDLE);
    copy_rd  = (sw_state == prf_pkg::SW_COPY) && (cnt < CNT_W'(DEPTH));
    raddr    = (sw_state == prf_pkg::SW_COPY) ? cnt[ADDR_W-1:0] : rd_addr;
    wk_we    = 1'b0;
    sh_we    = 1'b0;
    wk_waddr = wr_addr;
    sh_waddr = cp_wr_addr;
    wk_wdata = wr_data;
    sh_wdata = wk_q;
    if (sw_state == prf_pkg::SW_CLEAR) begin
      wk_we    = 1'b1;
      sh_we    = 1'b1;
      wk_waddr = cnt[ADDR_W-1:0];
      sh_waddr = cnt[ADDR_W-1:0];
      wk_wdata = '0;
      sh_wdata = '0;
    end else if (cp_wr_valid) begin
      if (dir == prf_pkg::DIR_SAVE) begin
        sh_we = 1'b1;
      end else begin
        wk_we    = 1'b1;
        wk_waddr = cp_wr_addr;
        wk_wdata = sh_q;
      end
    end else begin
      wk_we = wr_en;
    end
  end

  // Sweeper control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sw_state    <= prf_pkg::SW_CLEAR;
      cnt         <= '0;
      cp_wr_valid <= 1'b0;
      dir         <= prf_pkg::DIR_SAVE;
    end else begin
      sw_state    <= sw_state_next;
      cnt         <= cnt_next;
      cp_wr_valid <= copy_rd;
      if (sw_state == prf_pkg::SW_IDLE && sweep.go) begin
        dir <= sweep.dir;
      end
    end
  end

  // Copy write address is the registered read address, so it trails the read
  always_ff @(posedge clk) begin
    cp_wr_addr <= cnt[ADDR_W-1:0];
  end

  // Working store
  always_ff @(posedge clk) begin
    if (wk_we) begin
      working[wk_waddr] <= wk_wdata;
    end
    wk_q <= working[raddr];
  end

  // Shadow store
  always_ff @(posedge clk) begin
    if (sh_we) begin
      shadow[sh_waddr] <= sh_wdata;
    end
    sh_q <= shadow[raddr];
  end

  assign rd_data = wk_q;

endmodule

@@ rtl/paged_register_file_with_unlock.sv @@
// Paged register file with four-byte unlock key, NVM save/restore and soft reset.
// A request beat is held until its response beat is registered, which waits while
// the response side stalls; no new request is taken meanwhile. NVM save, NVM restore
// and soft reset then hold off the next request while the copy sweep runs.
// Reset (rst, synchronous): both stores are cleared in a pass over all
// PAGE_COUNT*REGS_PER_PAGE cells (266 by default); the config port is always ready.
module paged_register_file_with_unlock #(
  parameter int PAGE_COUNT    = 14,
  parameter int REGS_PER_PAGE = 19,
  parameter int KEY_LENGTH    = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  prf_pkg::prf_req_t           req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output prf_pkg::prf_rsp_t           rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [prf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                  cfg_data
);

  localparam int STORE_SIZE = PAGE_COUNT * REGS_PER_PAGE;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int KPOS_W     = $clog2(KEY_LENGTH + 1);
  localparam int KIDX_W     = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;

  prf_pkg::prf_state_t state, state_next;
  prf_pkg::prf_req_t   item;
  logic [ADDR_W-1:0]   item_cell;
  logic [prf_pkg::PAGE_W-1:0] cur_page, page_next;
  logic                cfg_mode, mode_next;
  logic [KPOS_W-1:0]   key_pos, kpos_next;
  logic [7:0]          key_bytes [KEY_LENGTH];
  logic [7:0]          cfg_regs [prf_pkg::CFG_COUNT];

  logic                accept;
  logic                out_load;
  logic                busy;
  logic [ADDR_W-1:0]   req_cell;
  logic [ADDR_W-1:0]   rd_cell;
  logic [7:0]          wk_rdata;
  logic                key_match;
  logic                key_we;
  logic                wr_intent;
  prf_pkg::prf_sweep_cmd_t sweep_intent, sweep;
  prf_pkg::prf_rsp_t   rsp_next;
  logic                item_paged;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign req_stall = (state != prf_pkg::ST_IDLE) || busy;
  assign accept    = req_valid && !req_stall;
  assign out_load  = (state == prf_pkg::ST_FINISH) && (!rsp_valid || !rsp_stall);

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      prf_pkg::ST_IDLE:   if (accept) state_next = prf_pkg::ST_FINISH;
      prf_pkg::ST_FINISH: if (out_load) state_next = prf_pkg::ST_IDLE;
      default:            state_next = prf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Store cell of the incoming request in the current page
  always_comb begin
    if (req.reg_addr < 8'(REGS_PER_PAGE)) begin
      req_cell = ADDR_W'(cur_page) * ADDR_W'(REGS_PER_PAGE) + ADDR_W'(req.reg_addr);
    end else begin
      req_cell = '0;
    end
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= req;
      item_cell <= req_cell;
    end
  end

  // Held request keeps its cell on the read port while the response waits
  assign rd_cell = (state == prf_pkg::ST_IDLE) ? req_cell : item_cell;

  assign item_paged = (item.reg_addr < 8'(REGS_PER_PAGE));

  // Key check: the byte being written completes the key
  always_comb begin
    key_match = 1'b1;
    for (int i = 0; i < KEY_LENGTH; i++) begin
      if (i == KEY_LENGTH - 1) begin
        if (item.write_data != prf_pkg::KEY_BASE + 8'(i)) key_match = 1'b0;
      end else begin
        if (key_bytes[i] != prf_pkg::KEY_BASE + 8'(i)) key_match = 1'b0;
      end
    end
  end

  // Sequencer outputs: response and state updates for the held request
  always_comb begin
    rsp_next     = '0;
    page_next    = cur_page;
    mode_next    = cfg_mode;
    kpos_next    = key_pos;
    key_we       = 1'b0;
    wr_intent    = 1'b0;
    sweep_intent = '{go: 1'b0, dir: prf_pkg::DIR_SAVE};
    unique case (prf_pkg::prf_op_t'(item.opcode))
      prf_pkg::OP_READ: begin
        priority if (item.reg_addr == cfg_regs[prf_pkg::CFG_PAGE_SELECT_ADDR]) begin
          rsp_next.read_data = 8'(cur_page);
        end else if (item.reg_addr == cfg_regs[prf_pkg::CFG_PRODUCT_ID_ADDR]) begin
          rsp_next.read_data = cfg_regs[prf_pkg::CFG_PRODUCT_ID_VALUE];
        end else if (item_paged) begin
          rsp_next.read_data = wk_rdata;
        end else begin
          rsp_next.status = 1'b1;
        end
      end
      prf_pkg::OP_WRITE: begin
        // any write elsewhere breaks the key sequence
        if (item.reg_addr != cfg_regs[prf_pkg::CFG_UNLOCK_KEY_ADDR]) kpos_next = '0;
        priority if (item.reg_addr == cfg_regs[prf_pkg::CFG_NVM_CONTROL_ADDR]) begin
          if (cfg_mode) begin
            priority if (item.write_data == cfg_regs[prf_pkg::CFG_NVM_SAVE_CODE]) begin
              sweep_intent = '{go: 1'b1, dir: prf_pkg::DIR_SAVE};
            end else if (item.write_data == cfg_regs[prf_pkg::CFG_NVM_RESTORE_CODE]) begin
              sweep_intent = '{go: 1'b1, dir: prf_pkg::DIR_RESTORE};
            end else begin
              sweep_intent.go = 1'b0;
            end
          end
        end else if (item.reg_addr == cfg_regs[prf_pkg::CFG_PAGE_SELECT_ADDR]) begin
          if (cfg_mode && item.write_data < 8'(PAGE_COUNT)) begin
            page_next = item.write_data[prf_pkg::PAGE_W-1:0];
          end
        end else if (item.reg_addr == cfg_regs[prf_pkg::CFG_UNLOCK_KEY_ADDR]) begin
          if (!cfg_mode && key_pos < KPOS_W'(KEY_LENGTH)) begin
            key_we    = 1'b1;
            kpos_next = key_pos + KPOS_W'(1);
            if (kpos_next == KPOS_W'(KEY_LENGTH) && key_match) mode_next = 1'b1;
          end
        end else if (item_paged) begin
          wr_intent = cfg_mode;
        end else begin
          rsp_next.status = 1'b1;
        end
      end
      prf_pkg::OP_SOFT_RESET: begin
        sweep_intent = '{go: 1'b1, dir: prf_pkg::DIR_RESTORE};
        page_next    = '0;
        mode_next    = 1'b0;
        kpos_next    = '0;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
    rsp_next.unlocked = mode_next;
  end

  assign sweep = '{go: sweep_intent.go && out_load, dir: sweep_intent.dir};

  // Control state commits when the response beat is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_page <= '0;
      cfg_mode <= 1'b0;
      key_pos  <= '0;
    end else if (out_load) begin
      cur_page <= page_next;
      cfg_mode <= mode_next;
      key_pos  <= kpos_next;
    end
  end

  // Received key bytes
  always_ff @(posedge clk) begin
    if (out_load && key_we) begin
      key_bytes[key_pos[KIDX_W-1:0]] <= item.write_data;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= rsp_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < prf_pkg::CFG_COUNT; i++) begin
        cfg_regs[i] <= prf_pkg::CFG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < prf_pkg::CFG_IDX_W'(prf_pkg::CFG_COUNT)) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // Page stores
  prf_pages #(
    .DEPTH (STORE_SIZE)
  ) u_pages (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_cell),
    .rd_data (wk_rdata),
    .wr_en   (wr_intent && out_load),
    .wr_addr (item_cell),
    .wr_data (item.write_data),
    .sweep   (sweep),
    .busy    (busy)
  );

endmodule

@@ rtl/prf_checker.sv @@
// Port-level checks for paged_register_file_with_unlock, bound to the top level.
// Depends on prf_pkg for the request and response beat types.
module prf_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input prf_pkg::prf_req_t req,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input prf_pkg::prf_rsp_t rsp
);

  // Out of reset: no response, stores being cleared
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !rsp_valid && req_stall)
    else $error("response or request window open right after reset");

  // One request in flight: the cycle after a request beat is stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in flight");

  // A new response follows a cycle in which requests were held off
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response appeared without request processing");

  // Error responses (invalid address, read or write) carry zero data
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.read_data == 8'd0)
    else $error("error response carries nonzero data");

  // Stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response beat changed");

endmodule

bind paged_register_file_with_unlock prf_checker u_prf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for paged_register_file_with_unlock: directed table, then random register traffic.
// Every response is checked vs a model of pages, key and lock, or a fixed row; needs prf_pkg.
module tb_top;

  localparam int PAGE_COUNT    = 14;
  localparam int REGS_PER_PAGE = 19;
  localparam int KEY_LENGTH    = 4;
  localparam int STORE_SIZE    = PAGE_COUNT * REGS_PER_PAGE;
  // copy or clear pass plus margin, waited out before touching the map
  localparam int REST_CYCLES   = STORE_SIZE + 16;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SEGMENT_ITEMS = 190;

  // Directed table row; expected response used only when fixed is set
  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        reg_addr;
    logic [7:0]        write_data;
    logic              fixed;
    prf_pkg::prf_rsp_t rsp;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  prf_pkg::prf_req_t req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  prf_pkg::prf_rsp_t rsp;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [prf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // typed expectation travels with the request beat
  logic              req_fixed = 1'b0;
  prf_pkg::prf_rsp_t req_fixed_rsp = '0;

  int send_idle_pct  = 10;
  int recv_stall_pct = 88;
  int mismatches     = 0;
  int accesses_sent  = 0;
  int responses_seen = 0;
  int cycles         = 0;

  // Model state
  logic [7:0]                 work_img   [STORE_SIZE];
  logic [7:0]                 shadow_img [STORE_SIZE];
  logic [prf_pkg::PAGE_W-1:0] page_sel;
  bit                         cfg_mode;
  int                         key_count;
  logic [7:0]                 key_seen   [KEY_LENGTH];
  logic [7:0]                 reg_map    [prf_pkg::CFG_COUNT];

  prf_pkg::prf_rsp_t outcomes_due [$];
  prf_pkg::prf_rsp_t predicted;
  prf_pkg::prf_rsp_t oldest;
  dir_row_t          dir_table [$];

  always #2 clk = ~clk;

  paged_register_file_with_unlock #(
    .PAGE_COUNT   (PAGE_COUNT),
    .REGS_PER_PAGE(REGS_PER_PAGE),
    .KEY_LENGTH   (KEY_LENGTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Effect of one register access on the model, and the response it owes
  function automatic prf_pkg::prf_rsp_t bus_access_outcome(prf_pkg::prf_req_t r);
    prf_pkg::prf_rsp_t o;
    int                slot;
    bit                key_ok;
    o = '0;
    slot = int'(page_sel) * REGS_PER_PAGE + int'(r.reg_addr);
    case (r.opcode)
      prf_pkg::OP_READ: begin
        if (r.reg_addr == reg_map[prf_pkg::CFG_PAGE_SELECT_ADDR]) begin
          o.read_data = 8'(page_sel);
        end else if (r.reg_addr == reg_map[prf_pkg::CFG_PRODUCT_ID_ADDR]) begin
          o.read_data = reg_map[prf_pkg::CFG_PRODUCT_ID_VALUE];
        end else if (r.reg_addr < REGS_PER_PAGE) begin
          o.read_data = work_img[slot];
        end else begin
          o.status = 1'b1;
        end
      end
      prf_pkg::OP_WRITE: begin
        // any write elsewhere restarts the key
        if (r.reg_addr != reg_map[prf_pkg::CFG_UNLOCK_KEY_ADDR]) key_count = 0;
        if (r.reg_addr == reg_map[prf_pkg::CFG_NVM_CONTROL_ADDR]) begin
          if (cfg_mode) begin
            if (r.write_data == reg_map[prf_pkg::CFG_NVM_SAVE_CODE]) shadow_img = work_img;
            else if (r.write_data == reg_map[prf_pkg::CFG_NVM_RESTORE_CODE])
              work_img = shadow_img;
          end
        end else if (r.reg_addr == reg_map[prf_pkg::CFG_PAGE_SELECT_ADDR]) begin
          if (cfg_mode && r.write_data < PAGE_COUNT)
            page_sel = r.write_data[prf_pkg::PAGE_W-1:0];
        end else if (r.reg_addr == reg_map[prf_pkg::CFG_UNLOCK_KEY_ADDR]) begin
          if (!cfg_mode && key_count < KEY_LENGTH) begin
            key_seen[key_count] = r.write_data;
            key_count++;
            if (key_count == KEY_LENGTH) begin
              key_ok = 1'b1;
              for (int i = 0; i < KEY_LENGTH; i++)
                if (key_seen[i] != 8'(prf_pkg::KEY_BASE + i)) key_ok = 1'b0;
              if (key_ok) cfg_mode = 1'b1;
            end
          end
        end else if (r.reg_addr < REGS_PER_PAGE) begin
          if (cfg_mode) work_img[slot] = r.write_data;
        end else begin
          o.status = 1'b1;
        end
      end
      prf_pkg::OP_SOFT_RESET: begin
        work_img  = shadow_img;
        page_sel  = '0;
        cfg_mode  = 1'b0;
        key_count = 0;
      end
      default: ;
    endcase
    o.unlocked = cfg_mode;
    return o;
  endfunction

  function automatic prf_pkg::prf_req_t mk_req(prf_pkg::prf_op_t op, logic [7:0] addr,
                                                logic [7:0] data);
    prf_pkg::prf_req_t r;
    r.opcode     = op;
    r.reg_addr   = addr;
    r.write_data = data;
    return r;
  endfunction

  // One ordinary access, weighted toward the paged range
  function automatic prf_pkg::prf_req_t pick_access();
    prf_pkg::prf_req_t r;
    int                sel;
    sel = $urandom_range(99);
    r = mk_req(prf_pkg::OP_READ, 8'($urandom_range(REGS_PER_PAGE - 1)), 8'($urandom));
    if (sel < 30) begin
      r.opcode = prf_pkg::OP_READ;
    end else if (sel < 60) begin
      r.opcode = prf_pkg::OP_WRITE;
    end else if (sel < 72) begin
      r.opcode   = prf_pkg::OP_WRITE;
      r.reg_addr = reg_map[prf_pkg::CFG_PAGE_SELECT_ADDR];
      if ($urandom_range(4) != 0) r.write_data = 8'($urandom_range(PAGE_COUNT - 1));
    end else if (sel < 80) begin
      r.reg_addr = reg_map[prf_pkg::CFG_PAGE_SELECT_ADDR];
    end else if (sel < 86) begin
      r.reg_addr = reg_map[prf_pkg::CFG_PRODUCT_ID_ADDR];
    end else begin
      r.opcode   = $urandom_range(1) ? prf_pkg::OP_WRITE : prf_pkg::OP_READ;
      r.reg_addr = 8'($urandom);
    end
    return r;
  endfunction

  // Drive one request beat and hold it until taken
  task automatic send_access(input prf_pkg::prf_req_t r, input logic fixed,
                             input prf_pkg::prf_rsp_t exp_rsp);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req           <= r;
    req_fixed     <= fixed;
    req_fixed_rsp <= exp_rsp;
    req_valid     <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Stop sending, collect every owed response, then let any copy finish
  task automatic drain_and_rest();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (REST_CYCLES) @(posedge clk);
  endtask

  // Write all map registers back to back
  task automatic program_map(input logic [7:0] vals [prf_pkg::CFG_COUNT]);
    prf_pkg::prf_cfg_idx_t idx;
    idx = idx.first();
    repeat (prf_pkg::CFG_COUNT) begin
      cfg_index <= idx;
      cfg_data  <= vals[idx];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      reg_map[idx] = vals[idx];
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input prf_pkg::prf_op_t op, input logic [7:0] addr,
                         input logic [7:0] data, input logic fixed, input logic [7:0] rd,
                         input logic st, input logic ul);
    dir_row_t row;
    row.opcode     = op;
    row.reg_addr   = addr;
    row.write_data = data;
    row.fixed      = fixed;
    row.rsp        = '{read_data: rd, status: st, unlocked: ul};
    dir_table.push_back(row);
  endtask

  // Random traffic: mostly unlock sequences and register bursts, some NVM and noise
  task automatic run_traffic(input int n_items);
    int                sent;
    int                kind;
    prf_pkg::prf_req_t r;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        for (int j = 0; j < KEY_LENGTH; j++) begin
          // an access slipped into the key sequence
          if ($urandom_range(14) == 0) begin
            send_access(pick_access(), 1'b0, '0);
            sent++;
          end
          r = mk_req(prf_pkg::OP_WRITE, reg_map[prf_pkg::CFG_UNLOCK_KEY_ADDR],
                     8'(prf_pkg::KEY_BASE + j));
          if ($urandom_range(11) == 0) r.write_data = 8'($urandom);
          send_access(r, 1'b0, '0);
          sent++;
        end
        // key byte past the end of the key
        if ($urandom_range(3) == 0) begin
          r.write_data = 8'($urandom);
          send_access(r, 1'b0, '0);
          sent++;
        end
      end else if (kind < 82) begin
        repeat ($urandom_range(1, 8)) begin
          send_access(pick_access(), 1'b0, '0);
          sent++;
        end
      end else if (kind < 88) begin
        case ($urandom_range(2))
          0:       r = mk_req(prf_pkg::OP_WRITE, reg_map[prf_pkg::CFG_NVM_CONTROL_ADDR],
                              reg_map[prf_pkg::CFG_NVM_SAVE_CODE]);
          1:       r = mk_req(prf_pkg::OP_WRITE, reg_map[prf_pkg::CFG_NVM_CONTROL_ADDR],
                              reg_map[prf_pkg::CFG_NVM_RESTORE_CODE]);
          default: r = mk_req(prf_pkg::OP_WRITE, reg_map[prf_pkg::CFG_NVM_CONTROL_ADDR],
                              8'($urandom));
        endcase
        send_access(r, 1'b0, '0);
        sent++;
      end else if (kind < 91) begin
        send_access(mk_req(prf_pkg::OP_SOFT_RESET, 8'($urandom), 8'($urandom)), 1'b0, '0);
        sent++;
      end else begin
        r = prf_pkg::prf_req_t'(18'($urandom));
        send_access(r, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Response stall
  always @(posedge clk) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses owed", cycles, outcomes_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // Response check first, then predict the beat taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        responses_seen++;
        if (outcomes_due.size() == 0) begin
          $error("response beat with none owed: %p", rsp);
          mismatches++;
        end else begin
          oldest = outcomes_due.pop_front();
          if (rsp.read_data !== oldest.read_data) begin
            $error("read_data: expected %02h, got %02h", oldest.read_data, rsp.read_data);
            mismatches++;
          end
          if (rsp.status !== oldest.status) begin
            $error("status: expected %0b, got %0b", oldest.status, rsp.status);
            mismatches++;
          end
          if (rsp.unlocked !== oldest.unlocked) begin
            $error("unlocked: expected %0b, got %0b", oldest.unlocked, rsp.unlocked);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        accesses_sent++;
        predicted = bus_access_outcome(req);
        if (req_fixed) predicted = req_fixed_rsp;
        outcomes_due.push_back(predicted);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] map_set [prf_pkg::CFG_COUNT];

    foreach (work_img[k]) begin
      work_img[k]   = '0;
      shadow_img[k] = '0;
    end
    foreach (key_seen[k]) key_seen[k] = '0;
    page_sel  = '0;
    cfg_mode  = 1'b0;
    key_count = 0;
    reg_map   = prf_pkg::CFG_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset map
    add_row(prf_pkg::OP_READ,  8'd0,   8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
    add_row(prf_pkg::OP_READ,  8'd33,  8'h00, 1'b1, 8'h45, 1'b0, 1'b0);
    add_row(prf_pkg::OP_READ,  8'd255, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0);
    add_row(prf_pkg::OP_WRITE, 8'd255, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b0);
    add_row(prf_pkg::OP_WRITE, 8'd0,   8'hAA, 1'b1, 8'h00, 1'b0, 1'b0);  // locked paged write
    add_row(prf_pkg::OP_WRITE, 8'd32,  8'h03, 1'b1, 8'h00, 1'b0, 1'b0);  // locked page select
    add_row(prf_pkg::OP_WRITE, 8'd35,  8'h01, 1'b1, 8'h00, 1'b0, 1'b0);  // locked save
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h24, 1'b1, 8'h00, 1'b0, 1'b0);
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h25, 1'b1, 8'h00, 1'b0, 1'b0);
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h26, 1'b1, 8'h00, 1'b0, 1'b0);
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h27, 1'b1, 8'h00, 1'b0, 1'b1);
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h24, 1'b1, 8'h00, 1'b0, 1'b1);  // key while unlocked
    add_row(prf_pkg::OP_WRITE, 8'd32,  8'h0D, 1'b1, 8'h00, 1'b0, 1'b1);  // last page
    add_row(prf_pkg::OP_WRITE, 8'd18,  8'hFF, 1'b1, 8'h00, 1'b0, 1'b1);
    add_row(prf_pkg::OP_READ,  8'd18,  8'h00, 1'b1, 8'hFF, 1'b0, 1'b1);
    add_row(prf_pkg::OP_WRITE, 8'd32,  8'h0E, 1'b1, 8'h00, 1'b0, 1'b1);  // page out of range
    add_row(prf_pkg::OP_READ,  8'd32,  8'h00, 1'b1, 8'h0D, 1'b0, 1'b1);
    add_row(prf_pkg::OP_WRITE, 8'd35,  8'h01, 1'b1, 8'h00, 1'b0, 1'b1);  // save
    add_row(prf_pkg::OP_WRITE, 8'd18,  8'h00, 1'b1, 8'h00, 1'b0, 1'b1);
    add_row(prf_pkg::OP_WRITE, 8'd35,  8'h02, 1'b1, 8'h00, 1'b0, 1'b1);  // restore
    add_row(prf_pkg::OP_READ,  8'd18,  8'h00, 1'b1, 8'hFF, 1'b0, 1'b1);
    add_row(prf_pkg::OP_WRITE, 8'd35,  8'h77, 1'b1, 8'h00, 1'b0, 1'b1);  // unknown code
    add_row(prf_pkg::OP_NOP,   8'hFF,  8'hFF, 1'b1, 8'h00, 1'b0, 1'b1);
    add_row(prf_pkg::OP_SOFT_RESET, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
    // wrong key, then a byte past the end
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h24, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h25, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h27, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(prf_pkg::OP_WRITE, 8'd34,  8'h27, 1'b0, 8'h00, 1'b0, 1'b0);
    add_row(prf_pkg::OP_READ,  8'd32,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0);

    foreach (dir_table[k])
      send_access(mk_req(prf_pkg::prf_op_t'(dir_table[k].opcode), dir_table[k].reg_addr,
                         dir_table[k].write_data), dir_table[k].fixed, dir_table[k].rsp);

    // Sender mostly busy, receiver mostly stalled
    run_traffic(SEGMENT_ITEMS);

    drain_and_rest();
    map_set[prf_pkg::CFG_PAGE_SELECT_ADDR] = 8'd0;
    map_set[prf_pkg::CFG_PRODUCT_ID_ADDR]  = 8'd255;
    map_set[prf_pkg::CFG_UNLOCK_KEY_ADDR]  = 8'd18;
    map_set[prf_pkg::CFG_NVM_CONTROL_ADDR] = 8'd254;
    map_set[prf_pkg::CFG_NVM_SAVE_CODE]    = 8'd0;
    map_set[prf_pkg::CFG_NVM_RESTORE_CODE] = 8'd255;
    map_set[prf_pkg::CFG_PRODUCT_ID_VALUE] = 8'd255;
    program_map(map_set);
    run_traffic(SEGMENT_ITEMS);

    // Sender mostly idle, receiver mostly ready
    send_idle_pct  = 88;
    recv_stall_pct = 10;
    drain_and_rest();
    // colliding addresses and equal NVM codes
    map_set[prf_pkg::CFG_PAGE_SELECT_ADDR] = 8'd200;
    map_set[prf_pkg::CFG_PRODUCT_ID_ADDR]  = 8'd200;
    map_set[prf_pkg::CFG_UNLOCK_KEY_ADDR]  = 8'd255;
    map_set[prf_pkg::CFG_NVM_CONTROL_ADDR] = 8'd0;
    map_set[prf_pkg::CFG_NVM_SAVE_CODE]    = 8'd128;
    map_set[prf_pkg::CFG_NVM_RESTORE_CODE] = 8'd128;
    map_set[prf_pkg::CFG_PRODUCT_ID_VALUE] = 8'd0;
    program_map(map_set);
    run_traffic(SEGMENT_ITEMS);

    drain_and_rest();
    foreach (map_set[k]) map_set[k] = 8'($urandom);
    program_map(map_set);
    run_traffic(SEGMENT_ITEMS);

    // No idling on either side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_and_rest();
    foreach (map_set[k]) map_set[k] = 8'($urandom);
    program_map(map_set);
    run_traffic(SEGMENT_ITEMS);

    drain_and_rest();
    program_map(prf_pkg::CFG_RESET);
    run_traffic(SEGMENT_ITEMS);

    drain_and_rest();
    $display("%0d accesses sent, %0d responses checked", accesses_sent, responses_seen);
    $display("six register maps, three idle patterns, %0d cycles", cycles);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/prf_pkg.sv
rtl/prf_pages.sv
rtl/paged_register_file_with_unlock.sv
rtl/prf_checker.sv
verif/tb_top.sv
